@@ hw/rtl/upsc_pkg.sv @@
// Package with the transaction types and signature constants of the UDP payload classifier.
`default_nettype none

package upsc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } upsc_byte_t;

  typedef struct packed {
    logic       detected;
    logic [1:0] matched_rule;
  } upsc_verdict_t;

  // Packet view after the current byte has been folded in.
  typedef struct packed {
    logic [15:0][7:0] header;
    logic [15:0]      trailing_pair;
    logic [31:0]      probe_word;
  } upsc_view_t;

  localparam logic [1:0] RULE_NONE  = 2'd0;
  localparam logic [1:0] RULE_LOGIN = 2'd1;
  localparam logic [1:0] RULE_SYNC  = 2'd2;
  localparam logic [1:0] RULE_NET   = 2'd3;

  localparam logic [31:0] LOGIN_SIG  = 32'h000b_0000;
  localparam logic [15:0] LOGIN_TAG  = 16'h0008;
  localparam logic [15:0] SYNC_SIG   = 16'h001c;
  localparam logic [31:0] SYNC_WORD1 = 32'h0000_0500;
  localparam logic [31:0] SYNC_WORD2 = 32'h0001_0000;
  localparam logic [15:0] NET_SIG    = 16'h0018;
  localparam logic [31:0] PROBE_A    = 32'h0001_0000;
  localparam logic [31:0] PROBE_B    = 32'h0000_0001;

  localparam int MIN_LEN     = 10;
  localparam int SYNC_LEN    = 16;
  localparam int NET_MIN_LEN = 50;
  localparam int SYNC_D      = 4;
  localparam int DLEN_BIAS   = 8;
  localparam int PROBE_BIAS  = 20;
  localparam int HDR_BYTES   = 16;

endpackage

`default_nettype wire

@@ hw/rtl/upsc_track.sv @@
// Per-packet state: byte counter, header bytes, trailing pair and net-sync probe word.
`default_nettype none

module upsc_track
  import upsc_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire upsc_byte_t             item,
  output upsc_view_t                  view,
  output logic [LENGTH_BITS-1:0]      len
);

  localparam int XW = 18;

  logic [LENGTH_BITS-1:0] byte_count;
  logic [LENGTH_BITS-1:0] byte_count_next;
  logic [15:0][7:0]       header;
  logic [15:0][7:0]       header_next;
  logic [15:0]            trailing_pair;
  logic [15:0]            trailing_pair_next;
  logic [31:0]            probe_word;
  logic [31:0]            probe_word_next;
  logic                   in_header;
  logic [15:0]            probe_pos;
  logic [XW-1:0]          probe_rel;
  logic                   in_probe;

  assign in_header = (byte_count[LENGTH_BITS-1:4] == '0);
  assign probe_pos = {header[14], header[15]};
  assign probe_rel = {{(XW-LENGTH_BITS){1'b0}}, byte_count} - XW'(HDR_BYTES)
                     - {2'b00, probe_pos};
  assign in_probe  = !in_header && !probe_rel[XW-1] && (probe_rel < XW'(4));

  always_comb begin
    header_next = header;
    if (in_header) begin
      header_next[byte_count[3:0]] = item.data_byte;
    end
  end

  assign probe_word_next    = in_probe ? {probe_word[23:0], item.data_byte} : probe_word;
  assign trailing_pair_next = {trailing_pair[7:0], item.data_byte};
  assign byte_count_next    = (byte_count == '1) ? byte_count : byte_count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      trailing_pair <= '0;
      probe_word    <= '0;
    end else if (step) begin
      if (item.last_byte) begin
        byte_count    <= '0;
        trailing_pair <= '0;
        probe_word    <= '0;
      end else begin
        byte_count    <= byte_count_next;
        trailing_pair <= trailing_pair_next;
        probe_word    <= probe_word_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      header <= header_next;
    end
  end

  assign view.header        = header_next;
  assign view.trailing_pair = trailing_pair_next;
  assign view.probe_word    = probe_word_next;
  assign len                = byte_count_next;

endmodule

`default_nettype wire

@@ hw/rtl/upsc_classify.sv @@
// Signature rules applied to the packet view at the final byte.
`default_nettype none

module upsc_classify
  import upsc_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  wire upsc_view_t             view,
  input  wire logic [LENGTH_BITS-1:0] len,
  output upsc_verdict_t               verdict
);

  localparam int XW = 18;

  logic [15:0][7:0] h;
  logic [XW-1:0]    len_x;
  logic [15:0]      d;
  logic [XW-1:0]    d_len;
  logic [XW-1:0]    p_len;
  logic             tail_ok;
  logic             login_hdr;
  logic             sync_hdr;
  logic             net_hdr;
  logic             probe_ok;
  logic [1:0]       rule;

  assign h       = view.header;
  assign len_x   = {{(XW-LENGTH_BITS){1'b0}}, len};
  assign d       = {h[4], h[5]};
  assign d_len   = {1'b0, d, 1'b0} + XW'(DLEN_BIAS);
  assign p_len   = {2'b00, h[14], h[15]} + XW'(PROBE_BIAS);
  assign tail_ok = (view.trailing_pair == '0);

  assign login_hdr = ({h[0], h[1], h[2], h[3]} == LOGIN_SIG);
  assign sync_hdr  = (len_x == XW'(SYNC_LEN)) && ({h[0], h[1]} == SYNC_SIG)
                     && ({h[2], h[3]} != '0);
  assign net_hdr   = (len_x > XW'(NET_MIN_LEN)) && ({h[0], h[1]} == NET_SIG)
                     && ({h[2], h[3]} != '0);
  assign probe_ok  = (view.probe_word == PROBE_A) || (view.probe_word == PROBE_B);

  always_comb begin
    rule = RULE_NONE;
    if (len_x <= XW'(MIN_LEN)) begin
      rule = RULE_NONE;
    end else if (login_hdr && (d == '0 || d_len != len_x)) begin
      rule = RULE_NONE;
    end else if (login_hdr && {h[6], h[7]} == LOGIN_TAG && tail_ok) begin
      rule = RULE_LOGIN;
    end else if (sync_hdr && d != 16'(SYNC_D)) begin
      rule = RULE_NONE;
    end else if (sync_hdr && {h[6], h[7], h[8], h[9]} == SYNC_WORD1
                 && {h[10], h[11], h[12], h[13]} == SYNC_WORD2 && tail_ok) begin
      rule = RULE_SYNC;
    end else if (net_hdr && (d == '0 || d_len > len_x)) begin
      rule = RULE_NONE;
    end else if (net_hdr && {h[8], h[9]} == {h[12], h[13]} && p_len < len_x
                 && probe_ok && tail_ok) begin
      rule = RULE_NET;
    end
  end

  assign verdict.detected     = (rule != RULE_NONE);
  assign verdict.matched_rule = rule;

endmodule

`default_nettype wire

@@ hw/rtl/udp_payload_signature_classifier.sv @@
// Top level of the UDP payload signature classifier.
// Takes one payload byte per clock on the payload channel unless stalled and,
// for every byte flagged as the final one, returns one verdict transaction
// through the input register and the verdict register; other bytes give no
// verdict. The block sustains one byte per cycle while not stalled, with the
// state update and rule check between the input register and the verdict
// register. The input side stalls only when a final byte is waiting while
// the verdict register still holds a verdict that has not been taken.
`default_nettype none

module udp_payload_signature_classifier
  import upsc_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    payload_valid,
  output logic         payload_stall,
  input  wire upsc_byte_t payload,
  output logic         verdict_valid,
  input  wire logic    verdict_stall,
  output upsc_verdict_t verdict
);

  logic                   held_valid;
  upsc_byte_t             held;
  logic                   out_free;
  logic                   advance;
  upsc_view_t             view;
  logic [LENGTH_BITS-1:0] len;
  upsc_verdict_t          verdict_next;

  assign out_free      = !verdict_valid || !verdict_stall;
  assign advance       = held_valid && (!held.last_byte || out_free);
  assign payload_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (payload_valid && !payload_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (payload_valid && !payload_stall) begin
      held <= payload;
    end
  end

  upsc_track #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_track (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (held),
    .view (view),
    .len  (len)
  );

  upsc_classify #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_classify (
    .view    (view),
    .len     (len),
    .verdict (verdict_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (advance && held.last_byte) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held.last_byte) begin
      verdict <= verdict_next;
    end
  end

endmodule

`default_nettype wire

@@ test/tb_udp_payload_signature_classifier.sv @@
// Testbench for the UDP payload signature classifier, checked against its own predictor.
`timescale 1ns / 1ps

module tb_udp_payload_signature_classifier;
  import upsc_pkg::*;

  localparam int LENGTH_BITS = 16;
  localparam int LEN_MAX = (1 << LENGTH_BITS) - 1;
  localparam int RANDOM_BYTES = 720;
  localparam int MIN_PACKETS = 10;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum int {PK_NOISE, PK_LOGIN, PK_SYNC, PK_NET} pkt_kind_t;

  typedef enum int {
    TW_NONE, TW_ZERO, TW_ONES, TW_BAD_D, TW_D_MAX, TW_BAD_TAG, TW_TAIL,
    TW_PROBE_B, TW_P_MAX, TW_P_OVER
  } tweak_t;

  typedef struct packed {
    upsc_byte_t    b;
    logic          fixed;
    upsc_verdict_t want;
  } feed_item_t;

  typedef struct {
    pkt_kind_t     kind;
    int            len;
    tweak_t        tw;
    bit            fixed;
    upsc_verdict_t want;
  } plan_row_t;

  plan_row_t plan [0:20] = '{
    '{PK_NOISE, 1,     TW_ZERO,    1'b1, '{1'b0, RULE_NONE}},
    '{PK_NOISE, 10,    TW_ONES,    1'b1, '{1'b0, RULE_NONE}},
    '{PK_NOISE, 10,    TW_ZERO,    1'b1, '{1'b0, RULE_NONE}},
    '{PK_LOGIN, 12,    TW_NONE,    1'b1, '{1'b1, RULE_LOGIN}},
    '{PK_LOGIN, 11,    TW_NONE,    1'b1, '{1'b0, RULE_NONE}},
    '{PK_LOGIN, 30,    TW_BAD_D,   1'b1, '{1'b0, RULE_NONE}},
    '{PK_LOGIN, 30,    TW_D_MAX,   1'b1, '{1'b0, RULE_NONE}},
    '{PK_LOGIN, 30,    TW_BAD_TAG, 1'b0, '{1'b0, RULE_NONE}},
    '{PK_LOGIN, 30,    TW_TAIL,    1'b0, '{1'b0, RULE_NONE}},
    '{PK_SYNC,  16,    TW_NONE,    1'b1, '{1'b1, RULE_SYNC}},
    '{PK_SYNC,  16,    TW_BAD_D,   1'b1, '{1'b0, RULE_NONE}},
    '{PK_SYNC,  16,    TW_BAD_TAG, 1'b0, '{1'b0, RULE_NONE}},
    '{PK_SYNC,  16,    TW_TAIL,    1'b0, '{1'b0, RULE_NONE}},
    '{PK_NET,   51,    TW_NONE,    1'b1, '{1'b1, RULE_NET}},
    '{PK_NET,   51,    TW_PROBE_B, 1'b0, '{1'b0, RULE_NONE}},
    '{PK_NET,   80,    TW_P_MAX,   1'b0, '{1'b0, RULE_NONE}},
    '{PK_NET,   80,    TW_P_OVER,  1'b0, '{1'b0, RULE_NONE}},
    '{PK_NET,   50,    TW_NONE,    1'b0, '{1'b0, RULE_NONE}},
    '{PK_NET,   80,    TW_BAD_D,   1'b1, '{1'b0, RULE_NONE}},
    '{PK_NET,   80,    TW_BAD_TAG, 1'b0, '{1'b0, RULE_NONE}},
    '{PK_NET,   80,    TW_TAIL,    1'b0, '{1'b0, RULE_NONE}}
  };

  logic          clk;
  logic          rst = 1'b1;
  logic          payload_valid = 1'b0;
  logic          payload_stall;
  upsc_byte_t    payload;
  logic          verdict_valid;
  logic          verdict_stall = 1'b0;
  upsc_verdict_t verdict;

  feed_item_t    byte_feed[$];
  feed_item_t    cur_item = '0;
  upsc_verdict_t pending_verdicts[$];
  bit [7:0]      pkt_buf[];

  int run_len = 0;
  bit [7:0] hdr_copy[16];
  bit [15:0] tail_copy = '0;
  bit [31:0] probe_copy = '0;

  logic in_took = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int free_left = 0;
  int bytes_taken = 0;
  int total_items = 0;
  int packets = 0;
  int verdicts_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int rule_hits[4] = '{0, 0, 0, 0};

  udp_payload_signature_classifier #(.LENGTH_BITS(LENGTH_BITS)) u_dut (
    .clk(clk),
    .rst(rst),
    .payload_valid(payload_valid),
    .payload_stall(payload_stall),
    .payload(payload),
    .verdict_valid(verdict_valid),
    .verdict_stall(verdict_stall),
    .verdict(verdict)
  );

  assign payload = cur_item.b;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int hdr16(input int pos);
    return int'({hdr_copy[pos & 15], hdr_copy[(pos + 1) & 15]});
  endfunction

  function automatic int hdr32(input int pos);
    return (hdr16(pos) << 16) | hdr16(pos + 2);
  endfunction

  function automatic logic [1:0] judge_payload(input int len);
    int dv;
    int pv;
    bit tail_ok;
    tail_ok = (tail_copy == 16'h0000);
    if (len <= MIN_LEN) return RULE_NONE;
    dv = hdr16(4);
    if (hdr32(0) == int'(LOGIN_SIG)) begin
      if (dv == 0 || dv * 2 + DLEN_BIAS != len) return RULE_NONE;
      if (hdr16(6) == int'(LOGIN_TAG) && tail_ok) return RULE_LOGIN;
    end
    if (len == SYNC_LEN && hdr16(0) == int'(SYNC_SIG) && hdr16(2) != 0) begin
      if (dv != SYNC_D) return RULE_NONE;
      if (hdr32(6) == int'(SYNC_WORD1) && hdr32(10) == int'(SYNC_WORD2) && tail_ok)
        return RULE_SYNC;
    end
    if (len > NET_MIN_LEN && hdr16(0) == int'(NET_SIG) && hdr16(2) != 0) begin
      if (dv == 0 || dv * 2 + DLEN_BIAS > len) return RULE_NONE;
      if (hdr16(8) == hdr16(12)) begin
        pv = hdr16(14);
        if (pv + PROBE_BIAS < len && (probe_copy == PROBE_A || probe_copy == PROBE_B) &&
            tail_ok)
          return RULE_NET;
      end
    end
    return RULE_NONE;
  endfunction

  task automatic absorb_byte(input feed_item_t it);
    int rel;
    int pv;
    logic [1:0] rule;
    upsc_verdict_t v;
    if (run_len < HDR_BYTES) begin
      hdr_copy[run_len] = it.b.data_byte;
    end else begin
      pv = hdr16(14);
      rel = run_len - HDR_BYTES;
      if (rel >= pv && rel - pv < 4) probe_copy = {probe_copy[23:0], it.b.data_byte};
    end
    tail_copy = {tail_copy[7:0], it.b.data_byte};
    if (run_len < LEN_MAX) run_len++;
    if (it.b.last_byte) begin
      rule = judge_payload(run_len);
      v.detected = (rule != RULE_NONE);
      v.matched_rule = rule;
      pending_verdicts.push_back(it.fixed ? it.want : v);
      run_len = 0;
      foreach (hdr_copy[i]) hdr_copy[i] = 8'h00;
      tail_copy = '0;
      probe_copy = '0;
    end
  endtask

  task automatic note_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic check_verdict(input upsc_verdict_t got);
    upsc_verdict_t want;
    if (pending_verdicts.size() == 0) begin
      note_error($sformatf("verdict with none pending: detected %0b rule %0d",
                           got.detected, got.matched_rule));
      return;
    end
    want = pending_verdicts.pop_front();
    verdicts_seen++;
    rule_hits[want.matched_rule]++;
    if (got.detected !== want.detected || got.matched_rule !== want.matched_rule)
      note_error($sformatf("verdict %0d: expected detected %0b rule %0d, got detected %0b rule %0d",
                           verdicts_seen, want.detected, want.matched_rule,
                           got.detected, got.matched_rule));
  endtask

  task automatic put_be(input int pos, input bit [31:0] val, input int n);
    for (int k = 0; k < n; k++)
      if (pos + k < pkt_buf.size()) pkt_buf[pos + k] = val[8 * (n - 1 - k) +: 8];
  endtask

  task automatic queue_packet(input pkt_kind_t kind, input int len, input tweak_t tw,
                              input bit fixed, input upsc_verdict_t want, input bit corrupt);
    int eff;
    int dv;
    int pv;
    bit [31:0] word;
    feed_item_t it;
    pkt_buf = new[len];
    eff = (len > LEN_MAX) ? LEN_MAX : len;
    foreach (pkt_buf[i])
      pkt_buf[i] = (tw == TW_ZERO) ? 8'h00 : (tw == TW_ONES) ? 8'hff :
                   8'($urandom_range(0, 255));
    case (kind)
      PK_LOGIN: begin
        dv = (eff - DLEN_BIAS) / 2;
        if (dv < 0) dv = 0;
        if (tw == TW_BAD_D) dv = dv + 1;
        if (tw == TW_D_MAX) dv = 32'h0000_ffff;
        put_be(0, LOGIN_SIG, 4);
        put_be(4, dv, 2);
        put_be(6, {16'h0000, LOGIN_TAG}, 2);
        if (tw == TW_BAD_TAG) put_be(7, $urandom_range(9, 255), 1);
      end
      PK_SYNC: begin
        put_be(0, {16'h0000, SYNC_SIG}, 2);
        put_be(2, $urandom_range(1, 65535), 2);
        put_be(4, (tw == TW_BAD_D) ? SYNC_D + 1 : SYNC_D, 2);
        put_be(6, SYNC_WORD1, 4);
        put_be(10, SYNC_WORD2, 4);
        if (tw == TW_BAD_TAG) put_be(9, $urandom_range(1, 255), 1);
      end
      PK_NET: begin
        put_be(0, {16'h0000, NET_SIG}, 2);
        put_be(2, $urandom_range(1, 65535), 2);
        dv = $urandom_range(1, (eff - DLEN_BIAS) / 2);
        if (tw == TW_BAD_D) dv = (eff - DLEN_BIAS) / 2 + 1;
        if (tw == TW_D_MAX) dv = 32'h0000_ffff;
        put_be(4, dv, 2);
        put_be(12, {16'h0000, pkt_buf[8], pkt_buf[9]}, 2);
        if (tw == TW_BAD_TAG) put_be(13, {24'h0, ~pkt_buf[9]}, 1);
        pv = $urandom_range(0, eff - PROBE_BIAS - 2);
        if (tw == TW_P_MAX) pv = eff - PROBE_BIAS - 1;
        if (tw == TW_P_OVER) pv = eff - PROBE_BIAS;
        put_be(14, pv, 2);
        if (tw == TW_PROBE_B) word = PROBE_B;
        else if (tw == TW_P_MAX) word = PROBE_A;
        else word = $urandom_range(0, 1) ? PROBE_A : PROBE_B;
        put_be(HDR_BYTES + pv, word, 4);
      end
      default: ;
    endcase
    if (kind != PK_NOISE) begin
      put_be(len - 2, 0, 2);
      if (tw == TW_TAIL) pkt_buf[len - 1 - $urandom_range(0, 1)] = 8'($urandom_range(1, 255));
    end
    if (corrupt) pkt_buf[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
    foreach (pkt_buf[i]) begin
      it.b.data_byte = pkt_buf[i];
      it.b.last_byte = (i == len - 1);
      it.fixed = fixed;
      it.want = want;
      byte_feed.push_back(it);
    end
    packets++;
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      payload_valid <= 1'b0;
    end else if (!payload_valid || in_took) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        payload_valid <= 1'b0;
      end else if (byte_feed.size() != 0) begin
        cur_item <= byte_feed.pop_front();
        payload_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) :
                        $urandom_range(1, 32);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        payload_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall runs alternate with free runs, some of them long.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      verdict_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left <= free_left - 1;
      verdict_stall <= 1'b0;
    end else begin
      verdict_stall <= 1'b0;
      hold_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      free_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                   $urandom_range(0, 15);
    end
  end

  // Every accepted transaction on either side is handled at the rising edge.
  always @(posedge clk) begin
    in_took <= !rst && payload_valid && !payload_stall;
    if (!rst && payload_valid && !payload_stall) begin
      absorb_byte(cur_item);
      bytes_taken++;
    end
    if (!rst && verdict_valid && !verdict_stall) check_verdict(verdict);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int rand_bytes;
    int pick;
    int len;
    pkt_kind_t kind;
    tweak_t tw;
    rand_bytes = 0;
    foreach (hdr_copy[i]) hdr_copy[i] = 8'h00;
    foreach (plan[i])
      queue_packet(plan[i].kind, plan[i].len, plan[i].tw, plan[i].fixed, plan[i].want, 1'b0);
    while (rand_bytes < RANDOM_BYTES || packets < MIN_PACKETS + $size(plan)) begin
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
        kind = PK_NOISE;
        len = $urandom_range(1, 30);
      end else if (pick < 8) begin
        kind = PK_LOGIN;
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : 2 * $urandom_range(6, 30);
      end else if (pick < 13) begin
        kind = PK_SYNC;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18) : SYNC_LEN;
      end else begin
        kind = PK_NET;
        len = $urandom_range(40, 120);
      end
      if ($urandom_range(0, 9) < 6) tw = TW_NONE;
      else if (kind == PK_NOISE) tw = tweak_t'($urandom_range(int'(TW_NONE), int'(TW_ONES)));
      else tw = tweak_t'($urandom_range(int'(TW_BAD_D), int'(TW_P_OVER)));
      queue_packet(kind, len, tw, 1'b0, '0, $urandom_range(0, 4) == 0);
      rand_bytes += len;
    end
    total_items = byte_feed.size();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    while (bytes_taken < total_items || pending_verdicts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("ran %0d payloads (%0d bytes) with random gaps and verdict stalls",
             packets, bytes_taken);
    $display("checked %0d verdicts: %0d login, %0d sync, %0d net sync, %0d excluded",
             verdicts_seen, rule_hits[RULE_LOGIN], rule_hits[RULE_SYNC],
             rule_hits[RULE_NET], rule_hits[RULE_NONE]);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
